// ----- src/bitmap_slot_allocator_unit_assert.svh -----
// assertion macros, clocked on clk, disabled while rst_n is low
`ifndef BITMAP_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsa assertion failed");

// next-cycle implication
`define BSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsa assertion failed");

`endif

// ----- src/bsa_pkg.sv -----
package bsa_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SLOT_W   = 9;
  localparam int unsigned GRANT_W  = 8;
  localparam int unsigned STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAN = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    logic              free_en;
    logic              clean;
    logic [SLOT_W-1:0] slot;
  } cell_cmd_t;

  // reported by each cell
  typedef struct packed {
    logic hit;
    logic fmatch;
  } cell_stat_t;

endpackage

// ----- src/bsa_req_if.sv -----
interface bsa_req_if;
  logic                        valid;
  logic                        ready;
  logic [bsa_pkg::KIND_W-1:0]  kind;
  logic [bsa_pkg::SLOT_W-1:0]  slot_to_free;

  modport source (output valid, output kind, output slot_to_free, input ready);
  modport sink (input valid, input kind, input slot_to_free, output ready);
endinterface

// ----- src/bsa_rsp_if.sv -----
interface bsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bsa_pkg::GRANT_W-1:0]   slot_granted;
  logic [bsa_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output slot_granted, output status, input ready);
  modport sink (input valid, input slot_granted, input status, output ready);
endinterface

// ----- src/bsa_cell.sv -----
module bsa_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned BW        = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_i,
  input  logic                tok_i,
  input  bsa_pkg::cell_cmd_t  cmd_i,
  output logic                tok_o,
  output bsa_pkg::cell_stat_t stat_o,
  output logic [BW-1:0]       bit_o
);

  localparam int unsigned BASE = IDX * WORD_BITS;

  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic                 tok_r, tok_nxt;
  logic                 active;
  logic                 full;
  logic [BW-1:0]        free_bit;
  logic [15:0]          slot_ext;
  logic                 fmatch;
  logic [BW-1:0]        fbit;

  assign active   = start_i | tok_i;
  assign full     = &word_r;
  assign slot_ext = 16'(cmd_i.slot);
  assign fmatch   = (slot_ext >= 16'(BASE)) && (slot_ext < 16'(BASE + WORD_BITS));
  assign fbit     = BW'(slot_ext - 16'(BASE));

  // lowest clear bit
  always_comb begin
    free_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word_r[i]) begin
        free_bit = BW'(i);
      end
    end
  end

  always_comb begin
    word_nxt = word_r;
    tok_nxt  = active && full;
    if (cmd_i.clean) begin
      word_nxt = '0;
    end else if (cmd_i.free_en && fmatch) begin
      word_nxt = word_r & ~(WORD_BITS'(1) << fbit);
    end else if (active && !full) begin
      word_nxt = word_r | (WORD_BITS'(1) << free_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
      tok_r  <= 1'b0;
    end else begin
      word_r <= word_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o         = tok_r;
  assign stat_o.hit    = active && !full;
  assign stat_o.fmatch = fmatch;
  assign bit_o         = (active && !full) ? free_bit : '0;

endmodule

// ----- src/bitmap_slot_allocator_unit.sv -----
// Slot allocator over WORDS x WORD_BITS slots, one bitmap word per cell in a chain.
// A free, a clean or an unused kind completes in the cycle it is accepted, with
// the result registered at that edge. An allocate starts at the cell of the hint
// word and a search token moves one cell per cycle up the chain; a full pool is
// reported once the token comes out of the last cell. One item is in work at a time;
// the next is taken while a finished result waits, as soon as the result register
// will be empty at that edge. No clearing pass is needed after reset.
`include "bitmap_slot_allocator_unit_assert.svh"

module bitmap_slot_allocator_unit #(
  parameter int unsigned WORDS     = 8,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  bsa_req_if.sink    in_req,
  bsa_rsp_if.source  out_rsp
);

  localparam int unsigned WW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned BW = $clog2(WORD_BITS);

  bsa_pkg::state_t     state_r, state_nxt;
  logic [WW-1:0]       hint_r, hint_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [bsa_pkg::GRANT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [bsa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                in_ready;
  logic                acc;
  logic                go;
  logic                outside;
  bsa_pkg::cell_cmd_t  cmd;
  logic [WORDS-1:0]    start_vec;
  logic [WORDS-1:0]    tok_vec;
  logic [WORDS-1:0]    hit_vec;
  logic [WORDS-1:0]    fmatch_vec;
  bsa_pkg::cell_stat_t stat_arr [WORDS];
  logic [BW-1:0]       bit_arr [WORDS];
  logic                hit_any;
  logic [WW-1:0]       hit_w;
  logic [BW-1:0]       hit_b;
  logic [WW-1:0]       free_w;
  logic [15:0]         grant_full;

  assign in_ready = (state_r == bsa_pkg::S_IDLE) && (!out_valid_r || out_rsp.ready);
  assign acc      = in_req.valid && in_ready;
  assign go       = acc && (in_req.kind == bsa_pkg::KIND_ALLOC);
  assign outside  = 16'(in_req.slot_to_free) >= 16'(WORDS * WORD_BITS);

  assign cmd.free_en = acc && (in_req.kind == bsa_pkg::KIND_FREE) && !outside;
  assign cmd.clean   = acc && (in_req.kind == bsa_pkg::KIND_CLEAN);
  assign cmd.slot    = in_req.slot_to_free;

  genvar k;
  generate
    for (k = 0; k < WORDS; k++) begin : g_cell
      logic tok_in;
      if (k == 0) begin : g_first
        assign tok_in = 1'b0;
      end else begin : g_next
        assign tok_in = tok_vec[k-1];
      end
      assign start_vec[k]  = go && (hint_r == WW'(k));
      assign hit_vec[k]    = stat_arr[k].hit;
      assign fmatch_vec[k] = stat_arr[k].fmatch;

      bsa_cell #(
        .IDX       (k),
        .WORD_BITS (WORD_BITS),
        .BW        (BW)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .start_i (start_vec[k]),
        .tok_i   (tok_in),
        .cmd_i   (cmd),
        .tok_o   (tok_vec[k]),
        .stat_o  (stat_arr[k]),
        .bit_o   (bit_arr[k])
      );
    end
  endgenerate

  // at most one cell hits and at most one matches, so or-encode
  always_comb begin
    hit_w  = '0;
    hit_b  = '0;
    free_w = '0;
    for (int i = 0; i < WORDS; i++) begin
      if (hit_vec[i]) begin
        hit_w = hit_w | WW'(i);
      end
      if (fmatch_vec[i]) begin
        free_w = free_w | WW'(i);
      end
      hit_b = hit_b | bit_arr[i];
    end
  end

  assign hit_any    = |hit_vec;
  assign grant_full = 16'(hit_w) * 16'(WORD_BITS) + 16'(hit_b);

  always_comb begin
    state_nxt      = state_r;
    hint_nxt       = hint_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    case (state_r)
      bsa_pkg::S_IDLE: begin
        if (acc) begin
          case (in_req.kind)
            bsa_pkg::KIND_ALLOC: begin
              if (hit_any) begin
                out_valid_nxt  = 1'b1;
                out_slot_nxt   = grant_full[bsa_pkg::GRANT_W-1:0];
                out_status_nxt = bsa_pkg::ST_DONE;
                hint_nxt       = hit_w;
              end else begin
                state_nxt = bsa_pkg::S_SCAN;
              end
            end
            bsa_pkg::KIND_FREE: begin
              out_valid_nxt = 1'b1;
              out_slot_nxt  = '0;
              if (outside) begin
                out_status_nxt = bsa_pkg::ST_OUTSIDE;
              end else begin
                out_status_nxt = bsa_pkg::ST_DONE;
                if (hint_r > free_w) begin
                  hint_nxt = free_w;
                end
              end
            end
            bsa_pkg::KIND_CLEAN: begin
              out_valid_nxt  = 1'b1;
              out_slot_nxt   = '0;
              out_status_nxt = bsa_pkg::ST_DONE;
              hint_nxt       = '0;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_slot_nxt   = '0;
              out_status_nxt = bsa_pkg::ST_DONE;
            end
          endcase
        end
      end
      bsa_pkg::S_SCAN: begin
        if (hit_any) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = grant_full[bsa_pkg::GRANT_W-1:0];
          out_status_nxt = bsa_pkg::ST_DONE;
          hint_nxt       = hit_w;
          state_nxt      = bsa_pkg::S_IDLE;
        end else if (tok_vec[WORDS-1]) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = '0;
          out_status_nxt = bsa_pkg::ST_FULL;
          state_nxt      = bsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bsa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsa_pkg::S_IDLE;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_req.ready         = in_ready;
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.slot_granted = out_slot_r;
  assign out_rsp.status       = out_status_r;

  `BSA_ASSERT_IMP(a_hit_onehot, 1'b1, $onehot0(hit_vec))
  `BSA_ASSERT_IMP(a_tok_onehot, 1'b1, $onehot0(tok_vec))
  `BSA_ASSERT_IMP(a_scan_out_empty, state_r == bsa_pkg::S_SCAN, !out_valid_r)
  `BSA_ASSERT_NEXT(a_miss_scans, go && !hit_any, state_r == bsa_pkg::S_SCAN)
  `BSA_ASSERT_NEXT(a_scan_hint_held, state_r == bsa_pkg::S_SCAN && !hit_any, $stable(hint_r))

endmodule

// ----- test/bitmap_slot_allocator_unit_test.sv -----
`timescale 1ns / 100ps

module bitmap_slot_allocator_unit_test;
  import bsa_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 4;
  localparam int POOL_WORDS   = 8;
  localparam int WORD_BITS    = 32;
  localparam int POOL_SLOTS   = POOL_WORDS * WORD_BITS;
  localparam int RANDOM_ITEMS = 1380;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int LONG_HOLD_AT     = 500;
  localparam int LONG_HOLD_CYCLES = 400;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam int MIX_MIXED = 0;
  localparam int MIX_FILL  = 1;
  localparam int MIX_DRAIN = 2;

  typedef struct packed {
    logic [GRANT_W-1:0]  slot_granted;
    logic [STATUS_W-1:0] status;
  } grant_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic              pinned;
    grant_t            pinned_res;
  } stim_row_t;

  localparam int DIRECTED_COUNT = 20;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{KIND_ALLOC, 9'd0,   1'b1, '{8'd0, ST_DONE}},
    '{KIND_ALLOC, 9'd511, 1'b1, '{8'd1, ST_DONE}},
    '{KIND_ALLOC, 9'd0,   1'b0, '{8'd0, ST_DONE}},
    '{KIND_FREE,  9'd1,   1'b1, '{8'd0, ST_DONE}},
    '{KIND_ALLOC, 9'd0,   1'b0, '{8'd0, ST_DONE}},
    '{KIND_FREE,  9'd256, 1'b1, '{8'd0, ST_OUTSIDE}},
    '{KIND_FREE,  9'd511, 1'b1, '{8'd0, ST_OUTSIDE}},
    '{KIND_FREE,  9'd255, 1'b1, '{8'd0, ST_DONE}},
    '{KIND_FREE,  9'd0,   1'b1, '{8'd0, ST_DONE}},
    '{KIND_FREE,  9'd0,   1'b1, '{8'd0, ST_DONE}},
    '{KIND_SPARE, 9'd511, 1'b1, '{8'd0, ST_DONE}},
    '{KIND_ALLOC, 9'd0,   1'b0, '{8'd0, ST_DONE}},
    '{KIND_CLEAN, 9'h155, 1'b1, '{8'd0, ST_DONE}},
    '{KIND_ALLOC, 9'h0AA, 1'b1, '{8'd0, ST_DONE}},
    '{KIND_FREE,  9'h0AA, 1'b1, '{8'd0, ST_DONE}},
    '{KIND_FREE,  9'h100, 1'b1, '{8'd0, ST_OUTSIDE}},
    '{KIND_SPARE, 9'd0,   1'b1, '{8'd0, ST_DONE}},
    '{KIND_ALLOC, 9'd0,   1'b0, '{8'd0, ST_DONE}},
    '{KIND_FREE,  9'h1FE, 1'b1, '{8'd0, ST_OUTSIDE}},
    '{KIND_CLEAN, 9'd0,   1'b1, '{8'd0, ST_DONE}}
  };

  logic clk = 1'b0;
  logic rst_n;

  bsa_req_if req_ch ();
  bsa_rsp_if rsp_ch ();

  bitmap_slot_allocator_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // allocator mirror
  bit [WORD_BITS-1:0] usage_map [POOL_WORDS];
  bit [2:0]           scan_start;

  grant_t pending_grants [$];
  int     live_slots [$];
  int     failures;
  int     results_checked;
  bit     tx_calm;
  bit     rx_calm;

  function automatic grant_t allocator_step(input logic [KIND_W-1:0] k,
                                            input logic [SLOT_W-1:0] s);
    grant_t r;
    bit     found;
    int     w;
    int     b;
    r.slot_granted = '0;
    r.status = ST_DONE;
    found = 1'b0;
    case (k)
      KIND_ALLOC: begin
        for (w = scan_start; w < POOL_WORDS && !found; w++) begin
          for (b = 0; b < WORD_BITS && !found; b++) begin
            if (!usage_map[w][b]) begin
              usage_map[w][b] = 1'b1;
              scan_start = 3'(w);
              r.slot_granted = GRANT_W'(w * WORD_BITS + b);
              found = 1'b1;
            end
          end
        end
        if (!found) r.status = ST_FULL;
      end
      KIND_FREE: begin
        if (s >= POOL_SLOTS) begin
          r.status = ST_OUTSIDE;
        end else begin
          usage_map[s[7:5]][s[4:0]] = 1'b0;
          if (scan_start > s[7:5]) scan_start = s[7:5];
        end
      end
      KIND_CLEAN: begin
        for (w = 0; w < POOL_WORDS; w++) usage_map[w] = '0;
        scan_start = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic offer(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] s,
                       input bit pin, input grant_t pinned_res, input bit drain_first);
    grant_t got;
    int     gap;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    if (drain_first) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while (pending_grants.size() != 0);
    end else begin
      gap = idle_len(tx_calm);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= k;
    req_ch.slot_to_free <= s;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    got = allocator_step(k, s);
    if (pin) got = pinned_res;
    pending_grants.push_back(got);
    if (k == KIND_ALLOC && got.status == ST_DONE) live_slots.push_back(got.slot_granted);
    if (k == KIND_CLEAN) live_slots.delete();
  endtask

  task automatic random_item(input int mix, input bit drain_first);
    int                r;
    int                pick;
    int                idx;
    logic [KIND_W-1:0] k;
    logic [SLOT_W-1:0] s;
    r = $urandom_range(0, 99);
    s = SLOT_W'($urandom_range(0, 511));
    case (mix)
      MIX_FILL:  k = (r < 94) ? KIND_ALLOC : KIND_FREE;
      MIX_DRAIN: k = (r < 25) ? KIND_ALLOC : KIND_FREE;
      default: begin
        if (r < 50) k = KIND_ALLOC;
        else if (r < 92) k = KIND_FREE;
        else if (r < 95) k = KIND_CLEAN;
        else k = KIND_SPARE;
      end
    endcase
    if (k == KIND_FREE) begin
      pick = $urandom_range(0, 99);
      if (pick < 60 && live_slots.size() != 0) begin
        idx = $urandom_range(0, live_slots.size() - 1);
        s = SLOT_W'(live_slots[idx]);
        live_slots.delete(idx);
      end else if (pick < 90) begin
        s[8] = 1'b0;
      end
    end
    offer(k, s, 1'b0, '0, drain_first);
  endtask

  task automatic check_result();
    grant_t want;
    if (pending_grants.size() == 0) begin
      $error("result with nothing pending: slot_granted %0d status %0d",
             rsp_ch.slot_granted, rsp_ch.status);
      failures++;
    end else begin
      want = pending_grants.pop_front();
      if (rsp_ch.slot_granted !== want.slot_granted) begin
        $error("slot_granted: expected %0d, got %0d", want.slot_granted, rsp_ch.slot_granted);
        failures++;
      end
      if (rsp_ch.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
        failures++;
      end
    end
    results_checked++;
  endtask

  // result side
  initial begin
    int  stall_left;
    bit  long_hold_done;
    stall_left = 0;
    long_hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_result();
      if (results_checked == LONG_HOLD_AT && !long_hold_done) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD_CYCLES;
      end
      if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
      if (rst_n !== 1'b1) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left = idle_len(rx_calm);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int i;
    int sent;
    int mix;
    int chunk;
    int r;
    failures = 0;
    results_checked = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    for (i = 0; i < POOL_WORDS; i++) usage_map[i] = '0;
    scan_start = '0;
    rst_n <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.kind <= KIND_ALLOC;
    req_ch.slot_to_free <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIRECTED_COUNT; i++) begin
      offer(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].slot, DIRECTED_ROWS[i].pinned,
            DIRECTED_ROWS[i].pinned_res, 1'b0);
    end

    // first chunk fills the pool past full
    sent = 0;
    mix = MIX_FILL;
    chunk = 320;
    while (sent < RANDOM_ITEMS) begin
      for (i = 0; i < chunk && sent < RANDOM_ITEMS; i++) begin
        random_item(mix, sent == RANDOM_ITEMS / 2);
        sent++;
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        mix = MIX_MIXED;
        chunk = $urandom_range(20, 80);
      end else if (r < 75) begin
        mix = MIX_FILL;
        chunk = $urandom_range(150, 320);
      end else begin
        mix = MIX_DRAIN;
        chunk = $urandom_range(40, 150);
      end
    end
    req_ch.valid <= 1'b0;

    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/bsa_pkg.sv
src/bsa_req_if.sv
src/bsa_rsp_if.sv
src/bsa_cell.sv
src/bitmap_slot_allocator_unit.sv
test/bitmap_slot_allocator_unit_test.sv
